### rtl/sem_pkg.sv
package sem_pkg;

	// frame geometry
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int LINE_AW    = $clog2(MAX_WIDTH);
	localparam int COL_W      = 10;
	localparam int ROW_W      = 12;
	localparam int WID_W      = 11;
	localparam int HGT_W      = 13;

	// configuration port
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 13;
	localparam logic [CFG_IW-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [WID_W-1:0] WIDTH_RST  = 11'd640;
	localparam logic [HGT_W-1:0] HEIGHT_RST = 13'd480;

	// luma weights, 8-bit fixed point of 0.30 / 0.59 / 0.11
	localparam logic [15:0] LUMA_R = 16'd77;
	localparam logic [15:0] LUMA_G = 16'd151;
	localparam logic [15:0] LUMA_B = 16'd28;

	// gradient energy and its root
	localparam int SQ_W   = 21;
	localparam int ROOT_W = 11;
	localparam logic [SQ_W-1:0] SQ_TOP = {1'b1, {(SQ_W-1){1'b0}}};

	// floor(x/3) as (x*683)>>11, exact for x below 2048
	localparam int RECIP3_SH = 11;
	localparam logic [SQ_W-1:0] RECIP3 = 21'd683;

	typedef struct packed {
		logic busy;
		logic done;
	} sq_stat_t;

endpackage

### rtl/sem_isqrt.sv
module sem_isqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sem_pkg::SQ_W-1:0]  operand,
	output sem_pkg::sq_stat_t         stat,
	output logic [sem_pkg::ROOT_W-1:0] root
);
	import sem_pkg::*;

	logic [SQ_W-1:0] rem_q;
	logic [SQ_W-1:0] res_q;
	logic [SQ_W-1:0] bit_q;
	logic            done_q;
	logic [SQ_W-1:0] trial;

	// one result bit per cycle, two operand bits retired per step
	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (bit_q == SQ_W'(1));
			if (start) begin
				bit_q <= SQ_TOP;
			end else if (bit_q != '0) begin
				bit_q <= bit_q >> 2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= operand;
			res_q <= '0;
		end else if (bit_q != '0) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

	assign stat.busy = (bit_q != '0);
	assign stat.done = done_q;
	assign root      = res_q[ROOT_W-1:0];

endmodule

### rtl/sobel_edge_magnitude.sv
// pixel beats are taken only in the idle state; each then passes through load, gradient, root and emit
//   before the next is taken, paced by the 11-step shared square-root loop plus three result
//   slots; back pressure on the result side holds the emit state longer
// reset (arst_n low): counters and window clear, width 640, height 480;
//   the line store is not cleared and needs no clearing pass
module sobel_edge_magnitude (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [sem_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [sem_pkg::CFG_DW-1:0]  cfg_data,
	// pixel channel
	input  logic                        pix_valid,
	output logic                        pix_ready,
	input  logic [7:0]                  red,
	input  logic [7:0]                  green,
	input  logic [7:0]                  blue,
	// result channel
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [sem_pkg::COL_W-1:0]   out_col,
	output logic [sem_pkg::ROW_W-1:0]   out_row,
	output logic [7:0]                  magnitude,
	output logic                        frame_done
);
	import sem_pkg::*;

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a pixel beat
	localparam logic [2:0] ST_LOAD = 3'd1;  // window shift from the line read, line write back
	localparam logic [2:0] ST_GRAD = 3'd2;  // gradients, squares, root start
	localparam logic [2:0] ST_ROOT = 3'd3;  // root unit iterating
	localparam logic [2:0] ST_EMIT = 3'd4;  // up to three result slots

	// result slots, in emission order
	localparam logic [1:0] EM_UP   = 2'd0;  // pixel above-left of the new one
	localparam logic [1:0] EM_EDGE = 2'd1;  // right border of the row above
	localparam logic [1:0] EM_LAST = 2'd2;  // bottom row pixel itself

	logic [2:0]        state_q;
	logic [1:0]        em_q;

	logic [WID_W-1:0]  width_q;
	logic [HGT_W-1:0]  height_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;

	// ------------------------------------------------------------------
	// configuration: always ready, unknown indexes dropped
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data[WID_W-1:0];
				CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective geometry, clamped into the supported range
	logic [WID_W-1:0] wid_eff;
	logic [HGT_W-1:0] hgt_eff;
	logic [COL_W-1:0] wm1;
	logic [ROW_W-1:0] hm1;

	always_comb begin
		if (width_q == '0) begin
			wid_eff = WID_W'(1);
		end else if (width_q > WID_W'(MAX_WIDTH)) begin
			wid_eff = WID_W'(MAX_WIDTH);
		end else begin
			wid_eff = width_q;
		end
		if (height_q == '0) begin
			hgt_eff = HGT_W'(1);
		end else if (height_q > HGT_W'(MAX_HEIGHT)) begin
			hgt_eff = HGT_W'(MAX_HEIGHT);
		end else begin
			hgt_eff = height_q;
		end
	end

	assign wm1 = COL_W'(wid_eff - WID_W'(1));
	assign hm1 = ROW_W'(hgt_eff - HGT_W'(1));

	// ------------------------------------------------------------------
	// position of the incoming pixel and of the one after it
	// a count left beyond a shrunk geometry wraps before use
	// ------------------------------------------------------------------
	logic              col_wrap;
	logic [HGT_W-1:0]  row_inc;
	logic [COL_W-1:0]  col_pre;
	logic [ROW_W-1:0]  row_pre;
	logic [WID_W-1:0]  col_nx;
	logic [HGT_W-1:0]  row_nx;

	always_comb begin
		col_wrap = ({1'b0, col_q} >= wid_eff);
		col_pre  = col_wrap ? '0 : col_q;
		row_inc  = {1'b0, row_q} + (col_wrap ? HGT_W'(1) : HGT_W'(0));
		row_pre  = (row_inc >= hgt_eff) ? '0 : row_inc[ROW_W-1:0];
		col_nx   = {1'b0, col_pre} + WID_W'(1);
		row_nx   = {1'b0, row_pre} + HGT_W'(1);
	end

	// luma, 16-bit weighted sum then drop the fraction
	logic [15:0] luma_sum;
	assign luma_sum = 16'(red) * LUMA_R + 16'(green) * LUMA_G + 16'(blue) * LUMA_B;

	logic pix_take;
	assign pix_ready = (state_q == ST_IDLE);
	assign pix_take  = pix_valid && pix_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_take) begin
			if (col_nx >= wid_eff) begin
				col_q <= '0;
				row_q <= (row_nx >= hgt_eff) ? '0 : row_nx[ROW_W-1:0];
			end else begin
				col_q <= col_nx[COL_W-1:0];
				row_q <= row_pre;
			end
		end
	end

	// per-pixel context, captured with the beat
	logic [COL_W-1:0] c_s1;
	logic [ROW_W-1:0] r_s1;
	logic [7:0]       y_s1;
	logic             has_up_s1;
	logic             has_edge_s1;
	logic             has_last_s1;
	logic             last_col_s1;
	logic             interior_s1;

	always_ff @(posedge clk) begin
		if (pix_take) begin
			c_s1        <= col_pre;
			r_s1        <= row_pre;
			y_s1        <= luma_sum[15:8];
			has_up_s1   <= (row_pre != '0) && (col_pre != '0);
			has_edge_s1 <= (row_pre != '0) && (col_pre == wm1);
			has_last_s1 <= (row_pre == hm1);
			last_col_s1 <= (col_pre == wm1);
			interior_s1 <= (row_pre >= ROW_W'(2)) && (col_pre >= COL_W'(2));
		end
	end

	// ------------------------------------------------------------------
	// line store: one entry per column, [7:0] two rows up, [15:8] one row up
	// read on the beat, written back the next cycle; the next read waits
	// for the idle state again, so a one-column frame never races itself
	// ------------------------------------------------------------------
	logic [15:0] line_mem [MAX_WIDTH];
	logic [15:0] line_rd_s1;

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			line_mem[c_s1] <= {y_s1, line_rd_s1[15:8]};
		end
		if (pix_take) begin
			line_rd_s1 <= line_mem[col_pre];
		end
	end

	// 3x3 window, row-major, newest column on the right
	logic [7:0] win_q [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (state_q == ST_LOAD) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[3] <= win_q[4];
			win_q[4] <= win_q[5];
			win_q[6] <= win_q[7];
			win_q[7] <= win_q[8];
			win_q[2] <= line_rd_s1[7:0];
			win_q[5] <= line_rd_s1[15:8];
			win_q[8] <= y_s1;
		end
	end

	// ------------------------------------------------------------------
	// gradient magnitudes as positive minus negative taps, then squares
	// ------------------------------------------------------------------
	logic [9:0]      gx_p, gx_n, gy_p, gy_n;
	logic [9:0]      gx_abs, gy_abs;
	logic [SQ_W-1:0] grad_sq;

	always_comb begin
		gx_p   = 10'(win_q[2]) + (10'(win_q[5]) << 1) + 10'(win_q[8]);
		gx_n   = 10'(win_q[0]) + (10'(win_q[3]) << 1) + 10'(win_q[6]);
		gy_p   = 10'(win_q[6]) + (10'(win_q[7]) << 1) + 10'(win_q[8]);
		gy_n   = 10'(win_q[0]) + (10'(win_q[1]) << 1) + 10'(win_q[2]);
		gx_abs = (gx_p >= gx_n) ? gx_p - gx_n : gx_n - gx_p;
		gy_abs = (gy_p >= gy_n) ? gy_p - gy_n : gy_n - gy_p;
		grad_sq = SQ_W'(20'(gx_abs) * 20'(gx_abs)) + SQ_W'(20'(gy_abs) * 20'(gy_abs));
	end

	// shared root unit; it registers the energy at start
	logic              sq_start;
	sq_stat_t          sq_stat;
	logic [ROOT_W-1:0] sq_root;

	assign sq_start = (state_q == ST_GRAD);

	sem_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.operand (grad_sq),
		.stat    (sq_stat),
		.root    (sq_root)
	);

	// divide by three through the reciprocal, then clip to a byte
	logic [SQ_W-1:0]          div_prod;
	logic [SQ_W-RECIP3_SH-1:0] div_q3;
	logic [7:0]               mag_sat;
	logic [7:0]               mag_q;

	always_comb begin
		div_prod = SQ_W'(sq_root) * RECIP3;
		div_q3   = div_prod[SQ_W-1:RECIP3_SH];
		mag_sat  = (div_q3 > (SQ_W-RECIP3_SH)'(255)) ? 8'hff : div_q3[7:0];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ROOT && sq_stat.done) begin
			mag_q <= interior_s1 ? mag_sat : '0;
		end
	end

	// ------------------------------------------------------------------
	// result slots into the output register
	// ------------------------------------------------------------------
	logic em_cond;
	logic out_free;
	logic res_load;
	logic em_adv;

	always_comb begin
		case (em_q)
			EM_UP:   em_cond = has_up_s1;
			EM_EDGE: em_cond = has_edge_s1;
			EM_LAST: em_cond = has_last_s1;
			default: em_cond = 1'b0;
		endcase
	end

	assign out_free = !res_valid || res_ready;
	assign res_load = (state_q == ST_EMIT) && em_cond && out_free;
	assign em_adv   = (state_q == ST_EMIT) && (!em_cond || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			em_q    <= EM_UP;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pix_take) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: state_q <= ST_GRAD;
				ST_GRAD: state_q <= ST_ROOT;
				ST_ROOT: begin
					if (sq_stat.done) begin
						state_q <= ST_EMIT;
						em_q    <= EM_UP;
					end
				end
				ST_EMIT: begin
					if (em_adv) begin
						if (em_q == EM_LAST) begin
							state_q <= ST_IDLE;
						end else begin
							em_q <= em_q + 2'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register, parts the pixel side from the result side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (res_load) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			case (em_q)
				EM_UP: begin
					out_col    <= c_s1 - COL_W'(1);
					out_row    <= r_s1 - ROW_W'(1);
					magnitude  <= mag_q;
					frame_done <= 1'b0;
				end
				EM_EDGE: begin
					out_col    <= c_s1;
					out_row    <= r_s1 - ROW_W'(1);
					magnitude  <= '0;
					frame_done <= 1'b0;
				end
				default: begin
					out_col    <= c_s1;
					out_row    <= r_s1;
					magnitude  <= '0;
					frame_done <= last_col_s1;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	a_take_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		pix_take |=> state_q == ST_LOAD)
		else $error("pixel beat not followed by line store write back");

	a_root_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		sq_start |-> !sq_stat.busy)
		else $error("root unit started while busy");

	a_root_done_emits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROOT && sq_stat.done |=> state_q == ST_EMIT && em_q == EM_UP)
		else $error("root result not handed to the result slots");

	a_border_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && magnitude != '0 |-> out_row != '0 && out_col != '0)
		else $error("nonzero magnitude on a border pixel");

endmodule
